[hdl/bfos_pkg.sv]
// Shared types, constants and the checksum adder for the block framer.
// Used by bfos_ctrl, bfos_dp and block_framer_with_ones_sum.
package bfos_pkg;

  localparam int BLOCK_BYTES = 18;
  localparam int POS_W       = $clog2(BLOCK_BYTES + 1);
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;

  localparam logic [7:0] PAD_FIRST_RST  = 8'd237;
  localparam logic [7:0] PAD_SECOND_RST = 8'd17;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_PAD_FIRST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_SECOND = 1'b1;

  // source of the byte loaded into the output register
  localparam logic [1:0] SRC_DATA   = 2'd0;
  localparam logic [1:0] SRC_PAD    = 2'd1;
  localparam logic [1:0] SRC_CHK_HI = 2'd2;
  localparam logic [1:0] SRC_CHK_LO = 2'd3;

  typedef struct packed {
    logic       load;    // load output register (and take byte if data/pad)
    logic [1:0] src;
    logic       padsel;  // 0: pad_first, 1: pad_second
    logic       clear;   // block done, reset position and sum
  } bfos_cmd_t;

  typedef struct packed {
    logic last_slot;     // next byte taken fills the block
  } bfos_stat_t;

  // ones'-complement add with end-around carry
  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] w);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, w};
    return s[15:0] + 16'(s[16]);
  endfunction

endpackage

[hdl/bfos_ctrl.sv]
// Sequencer for the block framer: data, pad and checksum phases, output valid.
// Depends on bfos_pkg; drives bfos_dp through a command struct.
module bfos_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                last_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output bfos_pkg::bfos_cmd_t cmd,
  input  bfos_pkg::bfos_stat_t stat
);
  import bfos_pkg::*;

  localparam logic [1:0] ST_DATA   = 2'd0;
  localparam logic [1:0] ST_PAD    = 2'd1;
  localparam logic [1:0] ST_CHK_HI = 2'd2;
  localparam logic [1:0] ST_CHK_LO = 2'd3;

  logic [1:0] state, state_next;
  logic       padsel, padsel_next;
  logic       out_valid_next;
  logic       adv;
  logic       accept;

  // output register free or emptying this cycle
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !(state == ST_DATA && adv);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next  = state;
    padsel_next = padsel;
    cmd.load    = 1'b0;
    cmd.src     = SRC_DATA;
    cmd.padsel  = padsel;
    cmd.clear   = 1'b0;
    case (state)
      ST_DATA: begin
        cmd.load = accept;
        cmd.src  = SRC_DATA;
        if (accept) begin
          if (stat.last_slot) begin
            state_next = ST_CHK_HI;
          end else if (last_byte) begin
            state_next  = ST_PAD;
            padsel_next = 1'b0;
          end
        end
      end
      ST_PAD: begin
        cmd.load = adv;
        cmd.src  = SRC_PAD;
        if (adv) begin
          padsel_next = !padsel;
          if (stat.last_slot) state_next = ST_CHK_HI;
        end
      end
      ST_CHK_HI: begin
        cmd.load = adv;
        cmd.src  = SRC_CHK_HI;
        if (adv) state_next = ST_CHK_LO;
      end
      ST_CHK_LO: begin
        cmd.load  = adv;
        cmd.src   = SRC_CHK_LO;
        cmd.clear = adv;
        if (adv) state_next = ST_DATA;
      end
      default: begin
        state_next = ST_DATA;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load) out_valid_next = 1'b1;
    else if (!out_stall) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_DATA;
      padsel    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      padsel    <= padsel_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

[hdl/bfos_dp.sv]
// Datapath of the block framer: pad registers, byte position, running sum,
// held high byte and the output payload register. Depends on bfos_pkg.
module bfos_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [bfos_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bfos_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [7:0]                         data_byte,
  input  bfos_pkg::bfos_cmd_t                cmd,
  output bfos_pkg::bfos_stat_t               stat,
  output logic [7:0]                         out_byte,
  output logic                               check_byte,
  output logic                               end_of_frame
);
  import bfos_pkg::*;

  logic [7:0]       pad_first, pad_second;
  logic [POS_W-1:0] byte_position;
  logic [15:0]      sum_accumulator;
  logic [7:0]       held_high_byte;

  logic [7:0]  take_b;
  logic        take;
  logic [15:0] sum_final;
  logic [15:0] chk;

  assign take   = cmd.load && (cmd.src == SRC_DATA || cmd.src == SRC_PAD);
  assign take_b = (cmd.src == SRC_PAD) ? (cmd.padsel ? pad_second : pad_first) : data_byte;

  // odd-length block: last byte pairs with a zero low byte
  assign sum_final = byte_position[0] ? ones_add(sum_accumulator, {held_high_byte, 8'h00})
                                      : sum_accumulator;
  assign chk       = ~sum_final;

  assign stat.last_slot = (byte_position == POS_W'(BLOCK_BYTES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_first  <= PAD_FIRST_RST;
      pad_second <= PAD_SECOND_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PAD_FIRST:  pad_first  <= cfg_data;
        REG_PAD_SECOND: pad_second <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      byte_position   <= '0;
      sum_accumulator <= '0;
      held_high_byte  <= '0;
    end else if (take) begin
      if (!byte_position[0]) held_high_byte <= take_b;
      else sum_accumulator <= ones_add(sum_accumulator, {held_high_byte, take_b});
      byte_position <= byte_position + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      case (cmd.src)
        SRC_CHK_HI: begin
          out_byte     <= chk[15:8];
          check_byte   <= 1'b1;
          end_of_frame <= 1'b0;
        end
        SRC_CHK_LO: begin
          out_byte     <= chk[7:0];
          check_byte   <= 1'b1;
          end_of_frame <= 1'b1;
        end
        default: begin
          out_byte     <= take_b;
          check_byte   <= 1'b0;
          end_of_frame <= 1'b0;
        end
      endcase
    end
  end

endmodule

[hdl/block_framer_with_ones_sum.sv]
// Block framer with 16-bit ones'-complement checksum trailer.
// Each accepted byte is in the output register the cycle after its transfer.
// Throughput: one data byte per cycle unless the output stalls; closing a block
// stalls the input while it sends its pad bytes and then two checksum bytes.
// Reset: synchronous; clears position, sum and held byte, pads to 237 and 17.
module block_framer_with_ones_sum (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bfos_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bfos_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      data_byte,
  input  logic                            last_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_byte,
  output logic                            check_byte,
  output logic                            end_of_frame
);
  import bfos_pkg::*;

  bfos_cmd_t  cmd;
  bfos_stat_t stat;

  bfos_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .last_byte (last_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  bfos_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .data_byte    (data_byte),
    .cmd          (cmd),
    .stat         (stat),
    .out_byte     (out_byte),
    .check_byte   (check_byte),
    .end_of_frame (end_of_frame)
  );

endmodule
